// File: hw/rtl/pgfv_pkg.sv
// shared types, constants and functions of the probe-grid file validator
// no dependencies

package pgfv_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 112;
  localparam int unsigned SH_VECTORS_DEF   = 7;
  localparam int unsigned PROBE_REC_DEF    = 116;
  localparam int unsigned CELL_REC_DEF     = 4;
  localparam int unsigned MAX_PROBES_DEF   = 4096;

  localparam int unsigned HDR_STORE = 112;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned REGION_W  = 16;
  localparam int unsigned VERDICT_W = 4;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hedb88320;
  localparam logic [WORD_W-1:0] CRC_INIT = 32'hffffffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC,
    CFG_VERSION,
    CFG_ENDIAN,
    CFG_MAX_REGION
  } cfg_idx_e;

  localparam logic [VERDICT_W-1:0] VC_OK     = 4'd0;
  localparam logic [VERDICT_W-1:0] VC_SHORT  = 4'd1;
  localparam logic [VERDICT_W-1:0] VC_IDENT  = 4'd2;
  localparam logic [VERDICT_W-1:0] VC_HDRCRC = 4'd3;
  localparam logic [VERDICT_W-1:0] VC_LAYOUT = 4'd4;
  localparam logic [VERDICT_W-1:0] VC_OFFSET = 4'd5;
  localparam logic [VERDICT_W-1:0] VC_ORIGIN = 4'd6;
  localparam logic [VERDICT_W-1:0] VC_PROBE  = 4'd7;
  localparam logic [VERDICT_W-1:0] VC_CELL   = 4'd8;

  // header word index (byte offset / 4)
  localparam logic [4:0] HW_MAGIC    = 5'd0;
  localparam logic [4:0] HW_VERSION  = 5'd1;
  localparam logic [4:0] HW_ENDIAN   = 5'd2;
  localparam logic [4:0] HW_HDRSIZE  = 5'd3;
  localparam logic [4:0] HW_SIZE_LO  = 5'd4;
  localparam logic [4:0] HW_SIZE_HI  = 5'd5;
  localparam logic [4:0] HW_DIM_X    = 5'd6;
  localparam logic [4:0] HW_DIM_Y    = 5'd7;
  localparam logic [4:0] HW_DIM_Z    = 5'd8;
  localparam logic [4:0] HW_PCOUNT   = 5'd9;
  localparam logic [4:0] HW_CCOUNT   = 5'd10;
  localparam logic [4:0] HW_RES0     = 5'd11;
  localparam logic [4:0] HW_ORIG_X   = 5'd12;
  localparam logic [4:0] HW_ORIG_Y   = 5'd13;
  localparam logic [4:0] HW_ORIG_Z   = 5'd14;
  localparam logic [4:0] HW_SPAC_X   = 5'd15;
  localparam logic [4:0] HW_SPAC_Y   = 5'd16;
  localparam logic [4:0] HW_SPAC_Z   = 5'd17;
  localparam logic [4:0] HW_POFF_LO  = 5'd18;
  localparam logic [4:0] HW_POFF_HI  = 5'd19;
  localparam logic [4:0] HW_COFF_LO  = 5'd20;
  localparam logic [4:0] HW_COFF_HI  = 5'd21;
  localparam logic [4:0] HW_PREC     = 5'd22;
  localparam logic [4:0] HW_CREC     = 5'd23;
  localparam logic [4:0] HW_PAYCRC   = 5'd24;
  localparam logic [4:0] HW_HDRCRC   = 5'd25;
  localparam logic [4:0] HW_RES1     = 5'd26;
  localparam logic [4:0] HW_RES2     = 5'd27;

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0]}});
    end
    return c;
  endfunction

  function automatic logic exp_all_ones(input logic [WORD_W-1:0] w);
    return w[30:23] == 8'hff;
  endfunction

endpackage

// File: hw/rtl/pgfv_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module pgfv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/probe_grid_file_validator_core.sv
// top level of the probe-grid file validator: byte parser, header checks,
// probe region memory and cell corner checker; uses pgfv_pkg and pgfv_ram
//
// Usage: the file enters one byte per transfer on the input channel
// (data_byte_i, last_byte_i, in_valid_i, in_stall_o); last_byte_i marks the
// final byte. The verdict and the grid figures leave as one transfer on the
// output channel (out_valid_o, out_stall_i) after the final byte.
// Bytes are taken one per cycle, except after the final byte until the verdict
// is registered, and in the cell section: every cell with a nonzero region id
// no larger than the max region id makes eight reads of the probe region ram,
// one per cycle, so the fourth byte of the next cell record waits until the
// previous cell's reads are issued. The verdict is computed combinationally
// and registered once any running cell check has ended and the output
// register is free. A stalled verdict stays in the output register; the next
// file streams in meanwhile and its verdict waits for that register to empty.
// Reset clears the parser state, the check flags and the registers (max region
// id to 255); no clearing pass is needed. Registers are written through
// cfg_valid_i, cfg_index_i and cfg_wdata_i, always ready.

module probe_grid_file_validator_core #(
  parameter int unsigned HEADER_BYTES       = pgfv_pkg::HEADER_BYTES_DEF,
  parameter int unsigned SH_VECTORS         = pgfv_pkg::SH_VECTORS_DEF,
  parameter int unsigned PROBE_RECORD_BYTES = pgfv_pkg::PROBE_REC_DEF,
  parameter int unsigned CELL_RECORD_BYTES  = pgfv_pkg::CELL_REC_DEF,
  parameter int unsigned MAX_PROBES         = pgfv_pkg::MAX_PROBES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pgfv_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pgfv_pkg::VERDICT_W-1:0]    verdict_code_o,
  output logic [pgfv_pkg::COUNT_W-1:0]      grid_x_o,
  output logic [pgfv_pkg::COUNT_W-1:0]      grid_y_o,
  output logic [pgfv_pkg::COUNT_W-1:0]      grid_z_o,
  output logic [pgfv_pkg::COUNT_W-1:0]      probe_total_o,
  output logic [pgfv_pkg::COUNT_W-1:0]      cell_total_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pgfv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pgfv_pkg::WORD_W-1:0]       cfg_wdata_i
);

  import pgfv_pkg::*;

  localparam int unsigned DIM_W  = $clog2(MAX_PROBES + 1);
  localparam int unsigned AW     = $clog2(MAX_PROBES);
  localparam int unsigned PW     = 2 * DIM_W;
  localparam int unsigned QW     = 3 * DIM_W;
  localparam int unsigned OW     = DIM_W + 11;
  localparam int unsigned RO_W   = $clog2(PROBE_RECORD_BYTES);
  localparam int unsigned SH_END = 4 + 16 * SH_VECTORS;

  localparam logic       ST_RUN    = 1'b0;
  localparam logic       ST_FINISH = 1'b1;

  localparam logic [1:0] SEC_PROBE = 2'd0;
  localparam logic [1:0] SEC_CELL  = 2'd1;
  localparam logic [1:0] SEC_DONE  = 2'd2;

  // configuration
  logic [WORD_W-1:0]   magic_cfg_q, version_cfg_q, endian_cfg_q;
  logic [REGION_W-1:0] max_id_q;

  // control
  logic                state_q, state_d;
  logic [63:0]         cnt_q, cnt_d;
  logic [WORD_W-1:0]   crc_q, crc_d, hdr_crc_q, hdr_crc_d, crc_step;
  logic [WORD_W-1:0]   wa_q, wa_d;
  logic [1:0]          sec_q, sec_d;
  logic [DIM_W-1:0]    rec_idx_q, rec_idx_d;
  logic [RO_W-1:0]     rec_off_q, rec_off_d;
  logic [DIM_W-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [AW-1:0]       base_q, base_d;
  logic                fail_probe_q, fail_probe_d, fail_cell_q, fail_cell_d;
  logic                misc_bad_q, misc_bad_d, fp_bad_q, fp_bad_d;
  logic                poff_bad_q, poff_bad_d, rec_bad_q, rec_bad_d;

  // header words
  logic [WORD_W-1:0]   magic_w_q, version_w_q, endian_w_q, size_lo_q, size_hi_q;
  logic [WORD_W-1:0]   dx_q, dy_q, dz_q, pcnt_q, ccnt_q, coff_lo_q, coff_hi_q;
  logic [WORD_W-1:0]   paycrc_q, hdrcrc_w_q;

  // layout arithmetic
  logic [PW-1:0]       xy_q, cxy_q;
  logic [QW-1:0]       pc_q, cc_q;
  logic [OW-1:0]       coff_exp_q, total_q;
  logic                layout_ok_q, layout_ok_d;
  logic [DIM_W-1:0]    dx_t, dy_t, dz_t;

  // cell corner engine
  logic                eng_busy_q;
  logic [2:0]          k_q;
  logic [AW-1:0]       eng_base_q;
  logic [REGION_W-1:0] eng_id_q, rd_id_q;
  logic                rd_v_q;
  logic                cell_start, cmp_bad;
  logic [AW-1:0]       ram_raddr;
  logic [REGION_W-1:0] ram_rdata;
  logic                ram_we;

  // output
  logic                   out_valid_q;
  logic [VERDICT_W-1:0]   verdict_q, verdict_d;
  logic [COUNT_W-1:0]     gx_q, gy_q, gz_q, pt_q, ct_q;
  logic                   lay_pass;

  // byte handling
  logic                in_acc, in_hdr, hdr_end, hdr_we, payload_en, cell_hold;
  logic                clr, out_free;
  logic [1:0]          pos;
  logic [4:0]          widx;
  logic [WORD_W-1:0]   word_full;
  logic [BYTE_W-1:0]   hdr_byte;
  logic [RO_W:0]       rec_off_n;
  logic [DIM_W:0]      rec_idx_n, cx_n, cy_n;

  assign in_hdr     = cnt_q < 64'(HEADER_BYTES);
  assign hdr_end    = cnt_q == 64'(HEADER_BYTES - 1);
  assign payload_en = !in_hdr && layout_ok_q && (sec_q != SEC_DONE);
  assign cell_hold  = payload_en && (sec_q == SEC_CELL) && (rec_off_q == RO_W'(3)) &&
                      eng_busy_q && (k_q != 3'd7);
  assign in_stall_o = (state_q == ST_FINISH) || cell_hold;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos        = in_hdr ? cnt_q[1:0] : rec_off_q[1:0];
  assign word_full  = {data_byte_i, wa_q[23:0]};
  assign widx       = cnt_q[6:2];
  assign hdr_we     = in_acc && (cnt_q < 64'(HDR_STORE)) && (pos == 2'd3);
  assign hdr_byte   = (cnt_q >= 64'd100 && cnt_q < 64'd104) ? 8'd0 : data_byte_i;
  assign crc_step   = crc_byte(crc_q, in_hdr ? hdr_byte : data_byte_i);
  assign rec_off_n  = {1'b0, rec_off_q} + 1'b1;
  assign rec_idx_n  = {1'b0, rec_idx_q} + 1'b1;
  assign cx_n       = {1'b0, cx_q} + 1'b1;
  assign cy_n       = {1'b0, cy_q} + 1'b1;
  assign dx_t       = dx_q[DIM_W-1:0];
  assign dy_t       = dy_q[DIM_W-1:0];
  assign dz_t       = dz_q[DIM_W-1:0];
  assign cfg_ready_o = 1'b1;

  // byte parser
  always_comb begin
    cnt_d        = cnt_q + 64'(cnt_q != '1);
    hdr_crc_d    = hdr_crc_q;
    crc_d        = crc_step;
    wa_d         = (pos == 2'd0) ? {24'd0, data_byte_i}
                                 : (wa_q | (32'(data_byte_i) << {pos, 3'b000}));
    sec_d        = sec_q;
    rec_idx_d    = rec_idx_q;
    rec_off_d    = rec_off_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    base_d       = base_q;
    fail_probe_d = fail_probe_q;
    fail_cell_d  = fail_cell_q;
    misc_bad_d   = misc_bad_q;
    fp_bad_d     = fp_bad_q;
    poff_bad_d   = poff_bad_q;
    rec_bad_d    = rec_bad_q;
    ram_we       = 1'b0;
    cell_start   = 1'b0;

    if (in_hdr && hdr_end) begin
      hdr_crc_d = ~crc_step;
      crc_d     = CRC_INIT;
    end

    if (hdr_we) begin
      unique case (widx)
        HW_HDRSIZE: if (word_full != 32'(HEADER_BYTES)) misc_bad_d = 1'b1;
        HW_RES0, HW_RES1, HW_RES2: if (word_full != '0) misc_bad_d = 1'b1;
        HW_ORIG_X, HW_ORIG_Y, HW_ORIG_Z: if (exp_all_ones(word_full)) fp_bad_d = 1'b1;
        HW_SPAC_X, HW_SPAC_Y, HW_SPAC_Z: begin
          if (exp_all_ones(word_full) || word_full[31] || word_full[30:0] == '0) begin
            fp_bad_d = 1'b1;
          end
        end
        HW_POFF_LO: if (word_full != 32'(HEADER_BYTES)) poff_bad_d = 1'b1;
        HW_POFF_HI: if (word_full != '0) poff_bad_d = 1'b1;
        HW_PREC:    if (word_full != 32'(PROBE_RECORD_BYTES)) rec_bad_d = 1'b1;
        HW_CREC:    if (word_full != 32'(CELL_RECORD_BYTES)) rec_bad_d = 1'b1;
        default: ;
      endcase
    end

    if (payload_en && sec_q == SEC_PROBE) begin
      if (rec_off_q == RO_W'(3)) begin
        if (word_full > 32'(max_id_q)) fail_probe_d = 1'b1;
        ram_we = in_acc;
      end else if (rec_off_q >= RO_W'(7) && rec_off_q[1:0] == 2'd3 &&
                   32'(rec_off_q) < SH_END) begin
        if (exp_all_ones(word_full)) fail_probe_d = 1'b1;
      end
      rec_off_d = rec_off_n[RO_W-1:0];
      if (rec_off_n >= (RO_W + 1)'(PROBE_RECORD_BYTES)) begin
        rec_off_d = '0;
        rec_idx_d = rec_idx_n[DIM_W-1:0];
        if (rec_idx_n >= {1'b0, pc_q[DIM_W-1:0]}) begin
          sec_d     = SEC_CELL;
          rec_idx_d = '0;
        end
      end
    end else if (payload_en && sec_q == SEC_CELL) begin
      if (rec_off_q == RO_W'(3)) begin
        if (word_full > 32'(max_id_q)) begin
          fail_cell_d = 1'b1;
        end else if (word_full != '0) begin
          cell_start = in_acc;
        end
      end
      rec_off_d = rec_off_n[RO_W-1:0];
      if (rec_off_n >= (RO_W + 1)'(CELL_RECORD_BYTES)) begin
        rec_off_d = '0;
        if (cx_n + 1'b1 >= {1'b0, dx_t}) begin
          cx_d = '0;
          if (cy_n + 1'b1 >= {1'b0, dy_t}) begin
            cy_d   = '0;
            base_d = base_q + AW'(2) + dx_q[AW-1:0];
          end else begin
            cy_d   = cy_n[DIM_W-1:0];
            base_d = base_q + AW'(2);
          end
        end else begin
          cx_d   = cx_n[DIM_W-1:0];
          base_d = base_q + AW'(1);
        end
        rec_idx_d = rec_idx_n[DIM_W-1:0];
        if (rec_idx_n >= {1'b0, cc_q[DIM_W-1:0]}) sec_d = SEC_DONE;
      end
    end
  end

  // verdict
  always_comb begin
    if (cnt_q < 64'(HEADER_BYTES)) begin
      verdict_d = VC_SHORT;
    end else if (magic_w_q != magic_cfg_q || version_w_q != version_cfg_q ||
                 endian_w_q != endian_cfg_q || misc_bad_q ||
                 {size_hi_q, size_lo_q} != cnt_q) begin
      verdict_d = VC_IDENT;
    end else if (hdrcrc_w_q != hdr_crc_q) begin
      verdict_d = VC_HDRCRC;
    end else if (!layout_ok_q) begin
      verdict_d = VC_LAYOUT;
    end else if (poff_bad_q || {coff_hi_q, coff_lo_q} != 64'(coff_exp_q) ||
                 64'(total_q) != cnt_q || paycrc_q != ~crc_q) begin
      verdict_d = VC_OFFSET;
    end else if (fp_bad_q) begin
      verdict_d = VC_ORIGIN;
    end else if (fail_probe_q) begin
      verdict_d = VC_PROBE;
    end else if (fail_cell_q) begin
      verdict_d = VC_CELL;
    end else begin
      verdict_d = VC_OK;
    end
    lay_pass = (verdict_d == VC_OK) || (verdict_d >= VC_OFFSET);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign clr      = (state_q == ST_FINISH) && !eng_busy_q && !rd_v_q && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:    if (in_acc && last_byte_i) state_d = ST_FINISH;
      ST_FINISH: if (clr) state_d = ST_RUN;
      default:   state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      cnt_q        <= '0;
      crc_q        <= CRC_INIT;
      hdr_crc_q    <= '0;
      wa_q         <= '0;
      sec_q        <= SEC_PROBE;
      rec_idx_q    <= '0;
      rec_off_q    <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      base_q       <= '0;
      fail_probe_q <= 1'b0;
      fail_cell_q  <= 1'b0;
      misc_bad_q   <= 1'b0;
      fp_bad_q     <= 1'b0;
      poff_bad_q   <= 1'b0;
      rec_bad_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        cnt_q        <= '0;
        crc_q        <= CRC_INIT;
        hdr_crc_q    <= '0;
        wa_q         <= '0;
        sec_q        <= SEC_PROBE;
        rec_idx_q    <= '0;
        rec_off_q    <= '0;
        cx_q         <= '0;
        cy_q         <= '0;
        base_q       <= '0;
        fail_probe_q <= 1'b0;
        fail_cell_q  <= 1'b0;
        misc_bad_q   <= 1'b0;
        fp_bad_q     <= 1'b0;
        poff_bad_q   <= 1'b0;
        rec_bad_q    <= 1'b0;
      end else begin
        if (in_acc) begin
          cnt_q        <= cnt_d;
          crc_q        <= crc_d;
          hdr_crc_q    <= hdr_crc_d;
          wa_q         <= wa_d;
          sec_q        <= sec_d;
          rec_idx_q    <= rec_idx_d;
          rec_off_q    <= rec_off_d;
          cx_q         <= cx_d;
          cy_q         <= cy_d;
          base_q       <= base_d;
          fail_probe_q <= fail_probe_d;
          misc_bad_q   <= misc_bad_d;
          fp_bad_q     <= fp_bad_d;
          poff_bad_q   <= poff_bad_d;
          rec_bad_q    <= rec_bad_d;
        end
        fail_cell_q <= (in_acc ? fail_cell_d : fail_cell_q) | cmp_bad;
      end
    end
  end

  // header words kept for the verdict and the layout
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      case (widx)
        HW_MAGIC:   magic_w_q   <= word_full;
        HW_VERSION: version_w_q <= word_full;
        HW_ENDIAN:  endian_w_q  <= word_full;
        HW_SIZE_LO: size_lo_q   <= word_full;
        HW_SIZE_HI: size_hi_q   <= word_full;
        HW_DIM_X:   dx_q        <= word_full;
        HW_DIM_Y:   dy_q        <= word_full;
        HW_DIM_Z:   dz_q        <= word_full;
        HW_PCOUNT:  pcnt_q      <= word_full;
        HW_CCOUNT:  ccnt_q      <= word_full;
        HW_COFF_LO: coff_lo_q   <= word_full;
        HW_COFF_HI: coff_hi_q   <= word_full;
        HW_PAYCRC:  paycrc_q    <= word_full;
        HW_HDRCRC:  hdrcrc_w_q  <= word_full;
        default: ;
      endcase
    end
  end

  // layout products, settled long before the payload starts
  always_ff @(posedge clk_i) begin
    xy_q       <= PW'(dx_t) * PW'(dy_t);
    cxy_q      <= PW'(dx_t - 1'b1) * PW'(dy_t - 1'b1);
    pc_q       <= QW'(xy_q) * QW'(dz_t);
    cc_q       <= QW'(cxy_q) * QW'(dz_t - 1'b1);
    coff_exp_q <= OW'(HEADER_BYTES) + OW'(pc_q[DIM_W-1:0]) * OW'(PROBE_RECORD_BYTES);
    total_q    <= coff_exp_q + OW'(cc_q[DIM_W-1:0]) * OW'(CELL_RECORD_BYTES);
  end

  assign layout_ok_d = dx_q >= 32'd2 && dy_q >= 32'd2 && dz_q >= 32'd2 &&
                       dx_q <= 32'(MAX_PROBES) && dy_q <= 32'(MAX_PROBES) &&
                       dz_q <= 32'(MAX_PROBES) && pc_q <= QW'(MAX_PROBES) &&
                       pcnt_q == 32'(pc_q[DIM_W-1:0]) && ccnt_q == 32'(cc_q[DIM_W-1:0]) &&
                       !rec_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_ok_q <= 1'b0;
    end else begin
      layout_ok_q <= layout_ok_d;
    end
  end

  // cell corner engine: eight reads, each compared in the next cycle
  assign ram_raddr = eng_base_q + (k_q[0] ? AW'(1) : AW'(0)) +
                     (k_q[1] ? dx_q[AW-1:0] : AW'(0)) +
                     (k_q[2] ? xy_q[AW-1:0] : AW'(0));
  assign cmp_bad   = rd_v_q && (ram_rdata != rd_id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_busy_q <= 1'b0;
      k_q        <= '0;
      rd_v_q     <= 1'b0;
    end else begin
      rd_v_q <= eng_busy_q;
      if (cell_start) begin
        eng_busy_q <= 1'b1;
        k_q        <= '0;
      end else if (eng_busy_q) begin
        k_q <= k_q + 3'd1;
        if (k_q == 3'd7) eng_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q <= eng_id_q;
    if (cell_start) begin
      eng_base_q <= base_q;
      eng_id_q   <= word_full[REGION_W-1:0];
    end
  end

  pgfv_ram #(
    .WIDTH(REGION_W),
    .DEPTH(MAX_PROBES)
  ) u_region_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(rec_idx_q[AW-1:0]),
    .wdata_i(word_full[REGION_W-1:0]),
    .re_i   (eng_busy_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg_q   <= '0;
      version_cfg_q <= '0;
      endian_cfg_q  <= '0;
      max_id_q      <= 16'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAGIC:      magic_cfg_q   <= cfg_wdata_i;
        CFG_VERSION:    version_cfg_q <= cfg_wdata_i;
        CFG_ENDIAN:     endian_cfg_q  <= cfg_wdata_i;
        CFG_MAX_REGION: max_id_q      <= cfg_wdata_i[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      verdict_q <= verdict_d;
      gx_q      <= lay_pass ? dx_q[COUNT_W-1:0] : '0;
      gy_q      <= lay_pass ? dy_q[COUNT_W-1:0] : '0;
      gz_q      <= lay_pass ? dz_q[COUNT_W-1:0] : '0;
      pt_q      <= (verdict_d == VC_OK) ? COUNT_W'(pc_q) : '0;
      ct_q      <= (verdict_d == VC_OK) ? COUNT_W'(cc_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_code_o = verdict_q;
  assign grid_x_o       = gx_q;
  assign grid_y_o       = gy_q;
  assign grid_z_o       = gz_q;
  assign probe_total_o  = pt_q;
  assign cell_total_o   = ct_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_start |-> (!eng_busy_q || k_q == 3'd7))
    else $error("cell check started over a running one");

  a_verdict_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("verdict raised outside finish");

  a_no_write_during_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !eng_busy_q && !rd_v_q)
    else $error("probe write during corner reads");

endmodule
